// ===== rtl/core/rtdc_pkg.sv =====
`timescale 1ns / 1ps
package rtdc_pkg;

    // default build values
    localparam int RTDC_CODE_BITS = 15;
    localparam int RTDC_FRAC_BITS = 24;

    // register and field widths
    localparam int REF_W  = 20;
    localparam int NOM_W  = 18;
    localparam int TEMP_W = 19;

    // register reset values
    localparam logic [REF_W-1:0] REF_RESET = 20'd43000;
    localparam logic [NOM_W-1:0] NOM_RESET = 18'd10000;

    // output limits in centidegrees
    localparam int TEMP_MAX = 200000;
    localparam int TEMP_MIN = -30000;

    // temperature clamp before scaling, in degrees
    localparam longint T_HI_DEG = 2100;
    localparam longint T_LO_DEG = -400;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_REF = 1'b0,
        CFG_NOM = 1'b1
    } t_cfg_idx;

    // round(num * 2^fb / den), halves rounded away from zero, worked out at elaboration
    function automatic logic signed [63:0] qconst(input longint num, input longint den,
                                                  input int fb);
        logic [127:0] n;
        logic [127:0] r;
        logic [127:0] q;
        logic [63:0]  mag;
        logic         neg;
        neg = (num < 0);
        mag = neg ? 64'(-num) : 64'(num);
        n   = {64'd0, mag} << (fb + 1);
        r   = '0;
        q   = '0;
        for (int i = 127; i >= 0; i--) begin
            r = {r[126:0], n[i]};
            q = {q[126:0], 1'b0};
            if (r >= 128'(den)) begin
                r    = r - 128'(den);
                q[0] = 1'b1;
            end
        end
        q = (q + 128'd1) >> 1;
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

endpackage

// ===== rtl/core/rtdc_div.sv =====
`timescale 1ns / 1ps
module rtdc_div
    import rtdc_pkg::*;
#(
    parameter int CODE_BITS = RTDC_CODE_BITS,
    parameter int FRAC_BITS = RTDC_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [CODE_BITS-1:0]   i_code,
    input  logic [REF_W-1:0]       i_ref,
    input  logic [NOM_W-1:0]       i_nom,
    output logic                   o_valid,
    output logic [FRAC_BITS+4:0]   o_x
);

    localparam int NW = CODE_BITS + REF_W;
    localparam int DW = CODE_BITS + NOM_W;
    localparam int RW = DW + 6;
    localparam int QW = FRAC_BITS + 5;
    localparam int NS = QW;
    localparam logic [QW-1:0] X_MAX = QW'(16) << FRAC_BITS;

    logic [NOM_W-1:0] n_nom_fix;
    logic [RW-1:0]    n_den;
    logic [NW-1:0]    n_num;

    logic          r_v   [0:NS];
    logic [RW-1:0] r_rem [0:NS];
    logic [QW-1:0] r_q   [0:NS];
    logic          r_ovf [0:NS];
    logic          r_out_v;
    logic [QW-1:0] r_x;

    // divisor from the nominal register, zero taken as one
    assign n_nom_fix = (i_nom == '0) ? NOM_W'(1) : i_nom;
    assign n_den     = RW'({n_nom_fix, {CODE_BITS{1'b0}}});
    assign n_num     = NW'(i_code) * NW'(i_ref);

    // numerator stage and overflow check against 32 times the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(n_num);
        r_q[0]   <= '0;
        r_ovf[0] <= (RW'(n_num) >= (n_den << 5));
    end

    // one quotient bit per stage, integer bits first
    for (genvar k = 1; k <= NS; k++) begin : g_stage
        logic [RW-1:0] n_rem_in;
        logic [RW-1:0] n_cmp;
        logic          n_ge;
        if (k <= 5) begin : g_int
            assign n_rem_in = r_rem[k-1];
            assign n_cmp    = n_den << (5 - k);
        end else begin : g_frac
            assign n_rem_in = {r_rem[k-1][RW-2:0], 1'b0};
            assign n_cmp    = n_den;
        end
        assign n_ge = (n_rem_in >= n_cmp);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? (n_rem_in - n_cmp) : n_rem_in;
            r_q[k]   <= {r_q[k-1][QW-2:0], n_ge};
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    // clamp ratio to 16
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= (r_ovf[NS] || (r_q[NS] > X_MAX)) ? X_MAX : r_q[NS];
    end

    assign o_valid = r_out_v;
    assign o_x     = r_x;

endmodule

// ===== rtl/core/rtdc_mul.sv =====
`timescale 1ns / 1ps
module rtdc_mul
    import rtdc_pkg::*;
#(
    parameter int A_W    = 32,
    parameter int B_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic signed [A_W+B_W-1:0]  o_p,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int AL  = A_W / 2;
    localparam int AH  = A_W - AL;
    localparam int BL  = B_W / 2;
    localparam int BH  = B_W - BL;
    localparam int P_W = A_W + B_W;

    logic signed [AL:0]   n_al;
    logic signed [AH-1:0] n_ah;
    logic signed [BL:0]   n_bl;
    logic signed [BH-1:0] n_bh;
    logic signed [P_W-1:0] n_p;

    logic                       r_v1;
    logic                       r_v2;
    logic signed [AL+BL+1:0]    r_ll;
    logic signed [AL+BH:0]      r_lh;
    logic signed [AH+BL:0]      r_hl;
    logic signed [AH+BH-1:0]    r_hh;
    logic [SIDE_W-1:0]          r_side1;
    logic [SIDE_W-1:0]          r_side2;
    logic signed [P_W-1:0]      r_p;

    // split operands into signed high and unsigned low halves
    assign n_al = $signed({1'b0, i_a[AL-1:0]});
    assign n_ah = $signed(i_a[A_W-1:AL]);
    assign n_bl = $signed({1'b0, i_b[BL-1:0]});
    assign n_bh = $signed(i_b[B_W-1:BL]);

    // partial products
    always_ff @(posedge i_clk) begin
        r_ll    <= n_al * n_bl;
        r_lh    <= n_al * n_bh;
        r_hl    <= n_ah * n_bl;
        r_hh    <= n_ah * n_bh;
        r_side1 <= i_side;
    end

    // recombine
    assign n_p = (P_W'(r_hh) <<< (AL + BL)) + (P_W'(r_hl) <<< AL)
               + (P_W'(r_lh) <<< BL) + P_W'(r_ll);

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_side2 <= r_side1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;
    assign o_side  = r_side2;

endmodule

// ===== rtl/core/rtdc_sqrt.sv =====
`timescale 1ns / 1ps
module rtdc_sqrt
    import rtdc_pkg::*;
#(
    parameter int FRAC_BITS = RTDC_FRAC_BITS,
    parameter int SIDE_W    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [FRAC_BITS:0]   i_u,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_root,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int RTW = FRAC_BITS + 1;
    localparam int RMW = FRAC_BITS + 3;
    localparam int NWD = 2 * FRAC_BITS + 2;
    localparam int NS  = RTW;

    logic              r_v    [0:NS];
    logic [NWD-1:0]    r_rad  [0:NS];
    logic [RMW-1:0]    r_rem  [0:NS];
    logic [RTW-1:0]    r_root [0:NS];
    logic [SIDE_W-1:0] r_side [0:NS];

    // radicand is u scaled up by the fraction width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= NWD'({i_u, {FRAC_BITS{1'b0}}});
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_side[0] <= i_side;
    end

    // one root bit per stage, two radicand bits consumed
    for (genvar k = 1; k <= NS; k++) begin : g_stage
        logic [RMW+1:0] n_rs;
        logic [RMW+1:0] n_trial;
        logic [RMW+1:0] n_rem;
        logic           n_ge;
        assign n_rs    = {r_rem[k-1], r_rad[k-1][NWD-1:NWD-2]};
        assign n_trial = (RMW+2)'({r_root[k-1], 2'b01});
        assign n_ge    = (n_rs >= n_trial);
        assign n_rem   = n_ge ? (n_rs - n_trial) : n_rs;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem[RMW-1:0];
            r_root[k] <= {r_root[k-1][RTW-2:0], n_ge};
            r_rad[k]  <= r_rad[k-1] << 2;
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_v[NS];
    assign o_root  = r_root[NS];
    assign o_side  = r_side[NS];

endmodule

// ===== rtl/core/rtd_code_to_temperature.sv =====
`timescale 1ns / 1ps
// RTD ratio code to temperature converter, fully pipelined.
// Input: a code transfer on i_start with i_rtd_code, taken when o_busy is low.
// o_busy is high only while reset is applied and in the cycle after it.
// Output: one result per code, shown for one cycle with o_valid, holding
// o_temperature_centidegree (0.01 C, signed), o_used_polynomial, o_saturated.
// Results come back in input order; the receiver cannot hold them off.
// Latency is set by the bit-per-stage ratio divider and the bit-per-stage
// square root. Throughput is one code per clock cycle while o_busy is low.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_wdata write the reference and
// nominal resistance registers; write them only while no code is in flight.
// Reset clears all valid bits and loads the register defaults (430.00 ohm
// reference, 100.00 ohm nominal); no clearing pass is needed.
module rtd_code_to_temperature
    import rtdc_pkg::*;
#(
    parameter int CODE_BITS          = RTDC_CODE_BITS,
    parameter int INTERNAL_FRAC_BITS = RTDC_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [CODE_BITS-1:0]     i_rtd_code,
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_index,
    input  logic [REF_W-1:0]         i_cfg_wdata,
    output logic                     o_valid,
    output logic signed [TEMP_W-1:0] o_temperature_centidegree,
    output logic                     o_used_polynomial,
    output logic                     o_saturated
);

    localparam int F   = INTERNAL_FRAC_BITS;
    localparam int XW  = F + 6;
    localparam int TPW = F + 24;
    localparam int KW  = F + 2;
    localparam int UW  = F + 3;
    localparam int OMW = F + 3;
    localparam int GW  = F + 13;
    localparam int TQW = F + 14;
    localparam int CW  = F + 13;
    localparam int SW  = F + 21;

    localparam logic signed [XW-1:0]  ONE_X = XW'(1) << F;
    localparam logic signed [UW-1:0]  ONE_U = UW'(1) << F;
    localparam logic signed [OMW-1:0] ONE_O = OMW'(1) << F;
    localparam logic signed [KW-1:0]  K_Q   = KW'(qconst(231000000, 1527480889, F));
    localparam logic signed [GW-1:0]  G_Q   = GW'(qconst(3908300, 1155, F));
    localparam logic signed [TPW-1:0] T_HI_Q = TPW'(T_HI_DEG <<< F);
    localparam logic signed [TPW-1:0] T_LO_Q = TPW'(T_LO_DEG <<< F);
    localparam logic signed [SW-1:0]  HALF_Q = SW'(1) << (F - 1);

    // polynomial coefficients, highest order first
    localparam logic signed [TPW-1:0] C_Q [0:5] = '{
        TPW'(qconst(15243, 10000, F)),
        TPW'(qconst(-28183, 10000, F)),
        TPW'(qconst(-4826, 1000, F)),
        TPW'(qconst(25859, 1000, F)),
        TPW'(qconst(22228, 100, F)),
        TPW'(qconst(-24202, 100, F))
    };

    // configuration registers
    logic [REF_W-1:0] r_ref;
    logic [NOM_W-1:0] r_nom;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= REF_RESET;
            r_nom  <= NOM_RESET;
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_REF: r_ref <= i_cfg_wdata;
                    CFG_NOM: r_nom <= i_cfg_wdata[NOM_W-1:0];
                    default: r_ref <= r_ref;
                endcase
            end
        end
    end

    assign o_busy = r_busy;

    // resistance ratio x
    logic         n_in_v;
    logic         div_v;
    logic [F+4:0] div_x;

    assign n_in_v = i_start && !r_busy;

    rtdc_div #(
        .CODE_BITS (CODE_BITS),
        .FRAC_BITS (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_in_v),
        .i_code  (i_rtd_code),
        .i_ref   (r_ref),
        .i_nom   (r_nom),
        .o_valid (div_v),
        .o_x     (div_x)
    );

    // polynomial in Horner form, one multiply and add per step
    logic                  r_h_v [0:4];
    logic signed [TPW-1:0] r_h_t [0:4];
    logic [F+4:0]          r_h_x [0:4];

    for (genvar i = 0; i < 5; i++) begin : g_horner
        logic                     n_v_in;
        logic signed [TPW-1:0]    n_t_in;
        logic [F+4:0]             n_x_in;
        logic                     m_v;
        logic signed [TPW+XW-1:0] m_p;
        logic [F+4:0]             m_x;
        logic signed [TPW-1:0]    n_t;

        if (i == 0) begin : g_first
            assign n_v_in = div_v;
            assign n_t_in = C_Q[0];
            assign n_x_in = div_x;
        end else begin : g_next
            assign n_v_in = r_h_v[i-1];
            assign n_t_in = r_h_t[i-1];
            assign n_x_in = r_h_x[i-1];
        end

        rtdc_mul #(
            .A_W    (TPW),
            .B_W    (XW),
            .SIDE_W (F + 5)
        ) u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (n_v_in),
            .i_a     (n_t_in),
            .i_b     ($signed({1'b0, n_x_in})),
            .i_side  (n_x_in),
            .o_valid (m_v),
            .o_p     (m_p),
            .o_side  (m_x)
        );

        assign n_t = $signed(m_p[F+TPW-1:F]) + C_Q[i+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_h_v[i] <= 1'b0;
            end else begin
                r_h_v[i] <= m_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_h_t[i] <= n_t;
            r_h_x[i] <= m_x;
        end
    end

    // quadratic: x minus one
    logic                  r_qa_v;
    logic signed [XW-1:0]  r_xm1;
    logic signed [TPW-1:0] r_qa_tp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa_v <= 1'b0;
        end else begin
            r_qa_v <= r_h_v[4];
        end
    end

    always_ff @(posedge i_clk) begin
        r_xm1   <= $signed({1'b0, r_h_x[4]}) - ONE_X;
        r_qa_tp <= r_h_t[4];
    end

    // K times (x - 1)
    logic                    mk_v;
    logic signed [KW+XW-1:0] mk_p;
    logic [TPW-1:0]          mk_tp;

    rtdc_mul #(
        .A_W    (KW),
        .B_W    (XW),
        .SIDE_W (TPW)
    ) u_mul_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_qa_v),
        .i_a     (K_Q),
        .i_b     (r_xm1),
        .i_side  (r_qa_tp),
        .o_valid (mk_v),
        .o_p     (mk_p),
        .o_side  (mk_tp)
    );

    // u = 1 - K (x - 1), negative u goes to the polynomial
    logic signed [UW-1:0] n_u;
    logic                 r_u_v;
    logic                 r_u_neg;
    logic [F:0]           r_u_mag;
    logic [TPW-1:0]       r_u_tp;

    assign n_u = ONE_U - $signed(mk_p[F+UW-1:F]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
        end else begin
            r_u_v <= mk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u_neg <= n_u[UW-1];
        r_u_mag <= n_u[UW-1] ? '0 : n_u[F:0];
        r_u_tp  <= mk_tp;
    end

    // square root of u
    logic           sq_v;
    logic [F:0]     sq_root;
    logic [TPW:0]   sq_side;

    rtdc_sqrt #(
        .FRAC_BITS (F),
        .SIDE_W    (TPW + 1)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_u_v),
        .i_u     (r_u_mag),
        .i_side  ({r_u_neg, r_u_tp}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // 1 - sqrt(u)
    logic                  r_om_v;
    logic signed [OMW-1:0] r_oms;
    logic [TPW:0]          r_om_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_om_v <= 1'b0;
        end else begin
            r_om_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oms     <= ONE_O - $signed({2'b00, sq_root});
        r_om_side <= sq_side;
    end

    // G times (1 - sqrt(u))
    logic                     mg_v;
    logic signed [GW+OMW-1:0] mg_p;
    logic [TPW:0]             mg_side;

    rtdc_mul #(
        .A_W    (GW),
        .B_W    (OMW),
        .SIDE_W (TPW + 1)
    ) u_mul_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_om_v),
        .i_a     (G_Q),
        .i_b     (r_oms),
        .i_side  (r_om_side),
        .o_valid (mg_v),
        .o_p     (mg_p),
        .o_side  (mg_side)
    );

    // pick quadratic or polynomial result and clamp to the degree range
    logic signed [TQW-1:0] n_tq;
    logic                  n_poly;
    logic signed [TPW-1:0] n_tsel;
    logic signed [TPW-1:0] n_tclamp;
    logic                  r_sel_v;
    logic signed [CW-1:0]  r_tc;
    logic                  r_sel_poly;

    assign n_tq   = $signed(mg_p[F+TQW-1:F]);
    assign n_poly = mg_side[TPW] || (n_tq <= 0);
    assign n_tsel = n_poly ? $signed(mg_side[TPW-1:0]) : TPW'(n_tq);

    always_comb begin
        priority if (n_tsel > T_HI_Q) begin
            n_tclamp = T_HI_Q;
        end else if (n_tsel < T_LO_Q) begin
            n_tclamp = T_LO_Q;
        end else begin
            n_tclamp = n_tsel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_v <= 1'b0;
        end else begin
            r_sel_v <= mg_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tc       <= n_tclamp[CW-1:0];
        r_sel_poly <= n_poly;
    end

    // scale to centidegrees and round half up
    logic signed [SW-1:0] n_tce;
    logic signed [SW-1:0] n_sc;
    logic                 r_sc_v;
    logic signed [20:0]   r_c;
    logic                 r_sc_poly;

    assign n_tce = SW'(r_tc);
    assign n_sc  = (n_tce <<< 6) + (n_tce <<< 5) + (n_tce <<< 2) + HALF_Q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_v <= 1'b0;
        end else begin
            r_sc_v <= r_sel_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c       <= $signed(n_sc[F+20:F]);
        r_sc_poly <= r_sel_poly;
    end

    // output clamp and result register
    logic signed [TEMP_W-1:0] n_temp;
    logic                     n_sat;
    logic                     r_out_v;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_poly;
    logic                     r_sat;

    always_comb begin
        priority if (r_c > 21'(TEMP_MAX)) begin
            n_temp = TEMP_W'(TEMP_MAX);
            n_sat  = 1'b1;
        end else if (r_c < 21'(TEMP_MIN)) begin
            n_temp = TEMP_W'(TEMP_MIN);
            n_sat  = 1'b1;
        end else begin
            n_temp = r_c[TEMP_W-1:0];
            n_sat  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_sc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp <= n_temp;
        r_sat  <= n_sat;
        r_poly <= r_sc_poly;
    end

    assign o_valid                   = r_out_v;
    assign o_temperature_centidegree = r_temp;
    assign o_used_polynomial         = r_poly;
    assign o_saturated               = r_sat;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import rtdc_pkg::*;

    localparam int CB        = 15;
    localparam int FB        = 24;
    localparam int WDOG_MAX  = 5000;
    localparam int DRAIN_CYC = 120;
    localparam longint ONE_Q = longint'(1) <<< FB;

    // one pending request: a code conversion or a register write
    typedef struct {
        logic          is_cfg;
        t_cfg_idx      idx;
        logic [19:0]   data;
        logic [CB-1:0] code;
        int            idle_pct;
    } t_conv_req;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic                     poly;
        logic                     sat;
    } t_temp_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic [CB-1:0]     i_rtd_code = '0;
    logic              i_cfg_we = 1'b0;
    logic [0:0]        i_cfg_index = '0;
    logic [REF_W-1:0]  i_cfg_wdata = '0;
    logic              o_busy;
    logic              o_valid;
    logic signed [TEMP_W-1:0] o_temperature_centidegree;
    logic              o_used_polynomial;
    logic              o_saturated;

    t_conv_req    conv_queue[$];
    t_temp_result temp_expect_q[$];
    logic [19:0]  ref_cfg = REF_RESET;
    logic [17:0]  nom_cfg = NOM_RESET;
    int n_codes_queued = 0;
    int n_codes_sent = 0;
    int n_results = 0;
    int n_poly = 0;
    int n_sat = 0;
    int n_cfg_writes = 0;
    int n_errors = 0;
    int idle_cycles = 0;

    rtd_code_to_temperature dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_start                   (i_start),
        .o_busy                    (o_busy),
        .i_rtd_code                (i_rtd_code),
        .i_cfg_we                  (i_cfg_we),
        .i_cfg_index               (i_cfg_index),
        .i_cfg_wdata               (i_cfg_wdata),
        .o_valid                   (o_valid),
        .o_temperature_centidegree (o_temperature_centidegree),
        .o_used_polynomial         (o_used_polynomial),
        .o_saturated               (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    // fixed-point constant, halves rounded away from zero
    function automatic longint fx_const(input longint num, input longint den);
        logic [127:0] mag;
        logic [127:0] v;
        mag = (num < 0) ? 128'(-num) : 128'(num);
        v   = (((mag << (FB + 1)) / 128'(den)) + 128'd1) >> 1;
        return (num < 0) ? -longint'(v[63:0]) : longint'(v[63:0]);
    endfunction

    // signed product floored to FB fraction bits, magnitude kept to 62 bits
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] p;
        logic [127:0] q;
        logic         neg;
        longint       r;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? 128'(-a) : 128'(a);
        mb  = (b < 0) ? 128'(-b) : 128'(b);
        p   = ma * mb;
        q   = (p >> FB) & ((128'd1 << 62) - 128'd1);
        r   = longint'(q[63:0]);
        if (neg)
            r = -r - ((p[FB-1:0] != '0) ? 1 : 0);
        return r;
    endfunction

    // floor(sqrt(u * 2^FB))
    function automatic longint fx_sqrt(input longint u);
        logic [127:0] target;
        logic [127:0] s;
        logic [127:0] cand;
        target = 128'(u) << FB;
        s = '0;
        for (int b = FB + 1; b >= 0; b--) begin
            cand = s | (128'd1 << b);
            if (cand * cand <= target)
                s = cand;
        end
        return longint'(s[63:0]);
    endfunction

    // expected conversion of one code under the given register values
    function automatic t_temp_result convert_code(input logic [CB-1:0] code,
                                                  input logic [19:0] rref,
                                                  input logic [17:0] rnom);
        t_temp_result res;
        logic [127:0] xw;
        logic [127:0] den;
        longint x;
        longint u;
        longint t;
        longint c;
        logic   poly;
        logic   sat;
        den = 128'((rnom == 0) ? 18'd1 : rnom) << CB;
        xw  = ((128'(code) * 128'(rref)) << FB) / den;
        if (xw > (128'd16 << FB))
            xw = 128'd16 << FB;
        x    = longint'(xw[63:0]);
        poly = 1'b1;
        sat  = 1'b0;
        t    = 0;
        // quadratic branch
        u = ONE_Q - fx_mul(fx_const(231000000, 1527480889), x - ONE_Q);
        if (u >= 0) begin
            t = fx_mul(fx_const(3908300, 1155), ONE_Q - fx_sqrt(u));
            if (t > 0)
                poly = 1'b0;
        end
        // fifth-order fallback in horner form
        if (poly) begin
            t = fx_const(15243, 10000);
            t = fx_mul(t, x) + fx_const(-28183, 10000);
            t = fx_mul(t, x) + fx_const(-4826, 1000);
            t = fx_mul(t, x) + fx_const(25859, 1000);
            t = fx_mul(t, x) + fx_const(22228, 100);
            t = fx_mul(t, x) + fx_const(-24202, 100);
        end
        if (t > T_HI_DEG * ONE_Q)
            t = T_HI_DEG * ONE_Q;
        if (t < T_LO_DEG * ONE_Q)
            t = T_LO_DEG * ONE_Q;
        c = (fx_mul(t, 100 * ONE_Q) + (longint'(1) <<< (FB - 1))) >>> FB;
        if (c > TEMP_MAX) begin
            c   = TEMP_MAX;
            sat = 1'b1;
        end else if (c < TEMP_MIN) begin
            c   = TEMP_MIN;
            sat = 1'b1;
        end
        res.temp = c[TEMP_W-1:0];
        res.poly = poly;
        res.sat  = sat;
        return res;
    endfunction

    function automatic void add_code(input logic [CB-1:0] code);
        t_conv_req r;
        r.is_cfg   = 1'b0;
        r.idx      = CFG_REF;
        r.data     = '0;
        r.code     = code;
        r.idle_pct = (n_codes_queued < 190) ? 17 : (n_codes_queued < 380) ? 47 : 0;
        conv_queue.push_back(r);
        n_codes_queued++;
    endfunction

    function automatic void add_cfg(input t_cfg_idx idx, input logic [19:0] data);
        t_conv_req r;
        r.is_cfg   = 1'b1;
        r.idx      = idx;
        r.data     = data;
        r.code     = '0;
        r.idle_pct = 0;
        conv_queue.push_back(r);
    endfunction

    // driver: code transfers and register writes from the pending queue
    always @(posedge i_clk) begin
        t_conv_req     head;
        logic          accepted;
        logic          nxt_start;
        logic          nxt_we;
        logic [CB-1:0] nxt_code;
        logic [0:0]    nxt_idx;
        logic [19:0]   nxt_data;
        nxt_start = i_start;
        nxt_we    = 1'b0;
        nxt_code  = i_rtd_code;
        nxt_idx   = i_cfg_index;
        nxt_data  = i_cfg_wdata;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            accepted = i_start && !o_busy;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_REF)
                    ref_cfg = i_cfg_wdata;
                else
                    nom_cfg = i_cfg_wdata[17:0];
                n_cfg_writes++;
            end
            if (accepted) begin
                temp_expect_q.push_back(convert_code(i_rtd_code, ref_cfg, nom_cfg));
                n_codes_sent++;
            end
            if (!i_start || accepted) begin
                nxt_start = 1'b0;
                if (conv_queue.size() > 0) begin
                    head = conv_queue[0];
                    if (head.is_cfg) begin
                        // registers change only with nothing in flight
                        if (temp_expect_q.size() == 0 && !o_valid && !accepted) begin
                            nxt_we   = 1'b1;
                            nxt_idx  = head.idx;
                            nxt_data = head.data;
                            void'(conv_queue.pop_front());
                        end
                    end else if ($urandom_range(99) >= head.idle_pct) begin
                        nxt_start = 1'b1;
                        nxt_code  = head.code;
                        void'(conv_queue.pop_front());
                    end
                end
            end
        end
        i_start     <= nxt_start;
        i_rtd_code  <= nxt_code;
        i_cfg_we    <= nxt_we;
        i_cfg_index <= nxt_idx;
        i_cfg_wdata <= nxt_data;
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_temp_result exp_r;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (temp_expect_q.size() == 0) begin
                $display("%0t: unexpected result temp=%0d poly=%0b sat=%0b", $time,
                         o_temperature_centidegree, o_used_polynomial, o_saturated);
                n_errors++;
            end else begin
                exp_r = temp_expect_q.pop_front();
                n_poly += exp_r.poly;
                n_sat  += exp_r.sat;
                if (o_temperature_centidegree !== exp_r.temp) begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             exp_r.temp, o_temperature_centidegree);
                    n_errors++;
                end
                if (o_used_polynomial !== exp_r.poly) begin
                    $display("%0t: used_polynomial expected %0b actual %0b", $time,
                             exp_r.poly, o_used_polynomial);
                    n_errors++;
                end
                if (o_saturated !== exp_r.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             exp_r.sat, o_saturated);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid || i_cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("%0t: watchdog expired", $time);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        longint zc;
        int     mode;
        // defaults: zero degree point, code extremes, bit patterns
        add_code(15'd0);
        add_code(15'd1);
        add_code(15'd7619);
        add_code(15'd7620);
        add_code(15'd7621);
        add_code(15'd16384);
        add_code(15'h2AAA);
        add_code(15'h5555);
        add_code(15'h7FFF);
        // huge ratio, x clamped and output saturated high
        add_cfg(CFG_REF, 20'hFFFFF);
        add_cfg(CFG_NOM, 20'd1000);
        add_code(15'h7FFF);
        add_code(15'd100);
        // zero reference and zero nominal
        add_cfg(CFG_REF, 20'd0);
        add_cfg(CFG_NOM, 20'd0);
        add_code(15'd5);
        add_code(15'h7FFF);
        // tiny ratio, x near zero
        add_cfg(CFG_REF, 20'd1);
        add_cfg(CFG_NOM, 20'h3FFFF);
        add_code(15'h7FFF);
        add_code(15'd0);
        add_cfg(CFG_REF, 20'd1000000);
        add_cfg(CFG_NOM, 20'd0);
        add_code(15'd1);
        add_code(15'h7FFF);
        // random blocks, each under a fresh register setting
        for (int blk = 0; blk < 11; blk++) begin
            logic [19:0] rv;
            logic [19:0] nv;
            mode = $urandom_range(9);
            if (mode < 5) begin
                rv = 20'($urandom_range(45000, 39000));
                nv = 20'($urandom_range(10100, 9900));
            end else if (mode < 8) begin
                rv = 20'($urandom_range(430000, 390000));
                nv = 20'($urandom_range(101000, 99000));
            end else begin
                rv = 20'($urandom);
                nv = 20'($urandom);
            end
            if (blk == 10) begin
                rv = 20'd1000000;
                nv = 20'd1000;
            end
            add_cfg(CFG_REF, rv);
            add_cfg(CFG_NOM, nv);
            zc = (longint'((nv[17:0] == 0) ? 1 : nv[17:0]) << CB) / ((rv == 0) ? 1 : rv);
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(4) == 0 && zc < 32767) begin
                    longint cv;
                    cv = zc + $urandom_range(400) - 200;
                    add_code((cv < 0) ? 15'd0 : (cv > 32767) ? 15'h7FFF : 15'(cv));
                end else begin
                    add_code(15'($urandom));
                end
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (conv_queue.size() > 0 || i_start || i_cfg_we || temp_expect_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("run covered %0d codes and %0d register writes, %0d results checked",
                 n_codes_sent, n_cfg_writes, n_results);
        $display("%0d results from the polynomial branch, %0d clamped", n_poly, n_sat);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
